[design/indexed_list_store_assert.svh]
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed_list_store: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed_list_store: next-cycle check failed");

`endif

[design/ils_pkg.sv]
// Types, constants and conversion functions of the indexed list store.
`default_nettype none

package ils_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Index and count widths that follow from the capacity.
  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Compare width that holds both the count and a request position.
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_LENGTH = 3'd5;

  typedef logic [DATA_WIDTH-1:0] cell_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         position;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [3:0]         found_position;
    logic [4:0]         length;
  } rsp_word_t;

  // Per-cell command broadcast by the controller.
  typedef struct packed {
    logic live;   // cell lies below the entry count
    logic load;   // take the request value
    logic shift;  // take the neighbor's value
  } cell_cmd_t;

  // Sign-extend or truncate a 32-bit value into a cell.
  function automatic cell_t to_cell(input logic signed [31:0] v);
    return DATA_WIDTH'(v);
  endfunction

  // Sign-extend or truncate a cell back into 32 bits.
  function automatic logic signed [31:0] from_cell(input cell_t c);
    return 32'(signed'(c));
  endfunction

endpackage

`default_nettype wire

[design/indexed_list_store.sv]
// Top level of the indexed list store: controller, cell chain and result register.
//
//   channel | words      | handshake              | width
//   --------+------------+------------------------+-------------------------------
//   req     | req_word_t | req_valid / req_stall  | opcode 3, position 4, value 32
//   rsp     | rsp_word_t | rsp_valid / rsp_stall  | ok 1, read 32, found 4, length 5
//
// Every word is executed at the edge where it is accepted and
// its result appears in the result register on the next cycle; the cells update
// at that same edge, so back-to-back words see each other's effects.
// Throughput is one word per cycle while rsp is drained; req stalls only while a
// result waits in the register under rsp_stall.
// Reset clears the entry count and rsp_valid; cell contents are never read unwritten.
`default_nettype none
`include "indexed_list_store_assert.svh"

module indexed_list_store import ils_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  logic             req_fire;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             in_range;
  logic             full;
  cell_t            key;

  logic append_ok;
  logic set_ok;
  logic remove_ok;

  cell_t               cell_data [CAPACITY];
  cell_t               cell_next [CAPACITY];
  cell_cmd_t           cell_cmd  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic             hit;
  logic [POS_W-1:0] hit_idx;
  rsp_word_t        result;

  // Hold the request while a finished result still waits downstream.
  assign req_stall = rsp_valid & rsp_stall;
  assign req_fire  = req_valid & ~req_stall;

  // Widen position and count to one compare width.
  assign pos_x    = CMP_W'(req.position);
  assign cnt_x    = CMP_W'(count);
  assign in_range = pos_x < cnt_x;
  assign full     = count == CNT_W'(CAPACITY);
  assign key      = to_cell(req.value);

  assign append_ok = req_fire && (req.opcode == OP_APPEND) && !full;
  assign set_ok    = req_fire && (req.opcode == OP_SET) && in_range;
  assign remove_ok = req_fire && (req.opcode == OP_REMOVE) && in_range;

  // Cell chain: each cell takes the request value or its upper neighbor's entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign cell_next[i] = cell_data[i];
    end else begin : g_mid
      assign cell_next[i] = cell_data[i+1];
    end

    // Append loads the cell at the count, set loads the cell at the position,
    // remove shifts every cell from the position up to the one below the top.
    assign cell_cmd[i].live  = CMP_W'(i) < cnt_x;
    assign cell_cmd[i].load  = (append_ok && (CMP_W'(i) == cnt_x)) ||
                               (set_ok && (CMP_W'(i) == pos_x));
    assign cell_cmd[i].shift = remove_ok && (CMP_W'(i) >= pos_x) &&
                               (CMP_W'(i + 1) < cnt_x);

    ils_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd[i]),
      .load_data (key),
      .next_data (cell_next[i]),
      .key       (key),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  // First matching cell wins: scan from the top so the lowest index stays.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_idx = POS_W'(i);
      end
    end
  end

  always_comb begin
    count_next            = count;
    result.ok             = 1'b0;
    result.read_value     = '0;
    result.found_position = '0;
    unique case (req.opcode)
      OP_APPEND: begin
        if (!full) begin
          result.ok  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_GET: begin
        if (in_range) begin
          result.ok         = 1'b1;
          result.read_value = from_cell(cell_data[pos_x[POS_W-1:0]]);
        end
      end
      OP_SET: begin
        result.ok = in_range;
      end
      OP_REMOVE: begin
        if (in_range) begin
          result.ok  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        result.ok             = hit;
        result.found_position = 4'(hit_idx);
      end
      OP_LENGTH: begin
        result.ok = 1'b1;
      end
      default: begin
        // Unused opcodes: report the length and nothing else.
      end
    endcase
    result.length = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_fire) begin
      count <= count_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp <= result;
    end
  end

  `ILS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `ILS_ASSERT_SAME(a_rsp_length, clk, rst, rsp_valid, rsp.length == 5'(count))
  `ILS_ASSERT_NEXT(a_append_grows, clk, rst, append_ok, count == $past(count) + 1'b1)
  `ILS_ASSERT_NEXT(a_remove_shrinks, clk, rst, remove_ok, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

[design/ils_cell.sv]
// One storage cell of the list chain: holds an entry, loads, shifts and compares.
`default_nettype none

module ils_cell import ils_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  cell_t     load_data,
  input  cell_t     next_data,
  input  cell_t     key,
  output cell_t     data,
  output logic      match
);

  cell_t data_next;

  always_comb begin
    priority if (cmd.load) begin
      data_next = load_data;
    end else if (cmd.shift) begin
      data_next = next_data;
    end else begin
      data_next = data;
    end
  end

  // Entry contents need no reset: only cells below the count are ever read.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign match = cmd.live && (data == key);

endmodule

`default_nettype wire

[tb/indexed_list_store_tb.sv]
// Self-checking testbench of the indexed list store: directed table, then random phases.
module indexed_list_store_tb;
  import ils_pkg::*;

  // Opcodes the block treats as no operation.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int PHASE_ITEMS  = 330;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    req_word_t word;
    int        reps;   // repeat count; the value advances by one per repeat
    bit        typed;  // expected word is given in the row, not predicted
    rsp_word_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  // Shadow copy of the list, updated on every accepted request word.
  logic signed [31:0] list_cells [CAPACITY];
  int                 list_len = 0;
  bit                 growing  = 1'b1;

  rsp_word_t list_results_due [$];
  dir_row_t  dir_rows [$];

  // Side information for the word currently on req.
  bit        word_typed = 1'b0;
  rsp_word_t word_want  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  indexed_list_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the word it yields.
  function automatic rsp_word_t apply_list_op(input req_word_t w);
    rsp_word_t r;
    int        p;
    int        i;
    r = '0;
    p = w.position;
    case (w.opcode)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_cells[list_len] = w.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (p < list_len) begin
          r.read_value = list_cells[p];
          r.ok = 1'b1;
        end
      end
      OP_SET: begin
        if (p < list_len) begin
          list_cells[p] = w.value;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Close the gap: later entries move one place toward the front.
        if (p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len; i++) begin
          if (!r.ok && list_cells[i] == w.value) begin
            r.ok = 1'b1;
            r.found_position = 4'(i);
          end
        end
      end
      OP_LENGTH: r.ok = 1'b1;
      default: ;
    endcase
    r.length = 5'(list_len);
    return r;
  endfunction

  // Mix wide random values with small ones (so searches hit duplicates) and extremes.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = 32'($urandom_range(7));
      7:          v = -32'sd1 - 32'($urandom_range(6));
      8:          v = 32'sh7fff_ffff;
      default:    v = 32'sh8000_0000;
    endcase
    return v;
  endfunction

  // Mostly in-range positions; swing between filling up and draining down.
  function automatic req_word_t pick_word();
    req_word_t w;
    int        roll;
    int        append_wt;
    if (list_len == CAPACITY) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    append_wt = growing ? 30 : 10;
    w.value    = pick_value();
    w.position = 4'($urandom_range(15));
    if (list_len > 0 && $urandom_range(99) < 85) w.position = 4'($urandom_range(list_len - 1));
    roll = $urandom_range(99);
    if (roll < 3) w.opcode = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
    else if (roll < 6) w.opcode = OP_LENGTH;
    else if (roll < 6 + append_wt) w.opcode = OP_APPEND;
    else if (roll < 46) w.opcode = OP_REMOVE;
    else if (roll < 64) w.opcode = OP_GET;
    else if (roll < 82) w.opcode = OP_SET;
    else begin
      w.opcode = OP_SEARCH;
      if (list_len > 0 && $urandom_range(99) < 70)
        w.value = list_cells[$urandom_range(list_len - 1)];
    end
    return w;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [3:0] pos,
                         input logic signed [31:0] val, input int reps, input bit typed,
                         input logic ok, input logic signed [31:0] rd,
                         input logic [3:0] fp, input logic [4:0] len);
    dir_row_t row;
    row.word.opcode        = op;
    row.word.position      = pos;
    row.word.value         = val;
    row.reps               = reps;
    row.typed              = typed;
    row.want.ok            = ok;
    row.want.read_value    = rd;
    row.want.found_position = fp;
    row.want.length        = len;
    dir_rows.push_back(row);
  endtask

  // Present one word from a falling edge and hold it until accepted.
  task automatic drive_word(input req_word_t w, input bit typed, input rsp_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid  = 1'b1;
    req        = w;
    word_typed = typed;
    word_want  = want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: stall at random, never during reset.
  always @(negedge clk) begin
    rsp_stall = !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Check results first, then predict for the request word taken at this edge;
  // a result never belongs to the request accepted at the same edge.
  always @(posedge clk) begin : result_check
    rsp_word_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (list_results_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %0h", $time, rsp);
          mismatch_count++;
        end else begin
          want = list_results_due.pop_front();
          report_field("ok", 32'(want.ok), 32'(rsp.ok));
          report_field("read_value", want.read_value, rsp.read_value);
          report_field("found_position", 32'(want.found_position), 32'(rsp.found_position));
          report_field("length", 32'(want.length), 32'(rsp.length));
        end
      end
      if (req_valid && !req_stall) begin
        want = apply_list_op(req);
        list_results_due.push_back(word_typed ? word_want : want);
      end
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    req_word_t w;
    int        k;
    int        phase;

    // Empty store, spare opcode, extremes, out-of-range, full store.
    add_row(OP_LENGTH, 4'd0, 32'sd0, 1, 1'b1, 1'b1, 32'sd0, 4'd0, 5'd0);
    add_row(OP_GET, 4'd0, 32'sd0, 1, 1'b1, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_SPARE_6, 4'd15, -32'sd1, 1, 1'b1, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_APPEND, 4'd0, 32'sh7fff_ffff, 1, 1'b1, 1'b1, 32'sd0, 4'd0, 5'd1);
    add_row(OP_APPEND, 4'd15, 32'sh8000_0000, 1, 1'b1, 1'b1, 32'sd0, 4'd0, 5'd2);
    add_row(OP_GET, 4'd0, 32'sd0, 1, 1'b1, 1'b1, 32'sh7fff_ffff, 4'd0, 5'd2);
    add_row(OP_GET, 4'd1, 32'sd0, 1, 1'b1, 1'b1, 32'sh8000_0000, 4'd0, 5'd2);
    add_row(OP_SEARCH, 4'd0, 32'sh8000_0000, 1, 1'b1, 1'b1, 32'sd0, 4'd1, 5'd2);
    add_row(OP_SET, 4'd2, 32'sd5, 1, 1'b1, 1'b0, 32'sd0, 4'd0, 5'd2);
    add_row(OP_SET, 4'd1, -32'sd1, 1, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_APPEND, 4'd0, 32'sh0000_1000, 14, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_APPEND, 4'd0, 32'sd9, 1, 1'b1, 1'b0, 32'sd0, 4'd0, 5'd16);
    add_row(OP_GET, 4'd15, 32'sd0, 1, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_SEARCH, 4'd0, 32'sh1234_5678, 1, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_REMOVE, 4'd15, 32'sd0, 1, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_REMOVE, 4'd0, 32'sd0, 1, 1'b0, 1'b0, 32'sd0, 4'd0, 5'd0);
    add_row(OP_REMOVE, 4'd15, 32'sd0, 1, 1'b1, 1'b0, 32'sd0, 4'd0, 5'd14);

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[n]) begin
      row = dir_rows[n];
      for (k = 0; k < row.reps; k++) begin
        w = row.word;
        w.value = row.word.value + 32'(k);
        drive_word(w, row.typed, row.want);
      end
    end

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      repeat (PHASE_ITEMS) drive_word(pick_word(), 1'b0, '0);
    end
    req_valid = 1'b0;

    // Drain outstanding results, then keep watching for stray result words.
    while (list_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
